// ===== rtl/core/mvof_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Motion vector outlier filter package
// Shared types, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package mvof_pkg;

	// Width of one stored entry: tracked flag, length, angle and the pair.
	localparam int ENTRY_W = 98;
	localparam int LEN_W   = 17;
	localparam int ANG_W   = 16;
	localparam int COORD_W = 16;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_SIGMA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SIGMA  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_ITER,
		ST_FIN,
		ST_SQ,
		ST_ACC,
		ST_PREP1,
		ST_PREP2,
		ST_PREP3,
		ST_RD,
		ST_EV1,
		ST_EV2,
		ST_EV3,
		ST_EV4,
		ST_DONE
	} state_t;

	// Arctangent steps in units of 2pi/2^20.
	function automatic logic [17:0] atan_step(input logic [3:0] i);
		logic [17:0] s;
		case (i)
			4'd0:  s = 18'd131072;
			4'd1:  s = 18'd77376;
			4'd2:  s = 18'd40884;
			4'd3:  s = 18'd20753;
			4'd4:  s = 18'd10417;
			4'd5:  s = 18'd5213;
			4'd6:  s = 18'd2607;
			4'd7:  s = 18'd1304;
			4'd8:  s = 18'd652;
			4'd9:  s = 18'd326;
			4'd10: s = 18'd163;
			4'd11: s = 18'd81;
			4'd12: s = 18'd41;
			4'd13: s = 18'd20;
			4'd14: s = 18'd10;
			default: s = 18'd5;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/mvof_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mvof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/motion_vector_outlier_filter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Motion vector outlier filter core
// Loads point pairs, computes move length and folded angle, then drops pairs that
// are untracked, too far or above the statistical band; emits kept ones in order.
// ---------------------------------------------------------------------------
// Loading: each pair passes through square, root iteration, finish, square and
// accumulate states; a new pair is accepted only once the core is back in idle.
// Filtering: after the last pair, states PREP1 to PREP3, then RD and EV1 to EV4
// per stored pair through the single read port of the entry memory, then DONE.
// A kept pair is output after the next keep decision or at done and cannot stall.
// Reset clears the counters, sums and control state; the memory is not cleared.
module motion_vector_outlier_filter_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] x_from,
	input  logic [15:0] y_from,
	input  logic [15:0] x_to,
	input  logic [15:0] y_to,
	input  logic        tracked,
	input  logic        last_point,
	input  logic        cfg_write,
	input  logic [mvof_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mvof_pkg::CFG_W-1:0]     cfg_data,
	output logic        strobe,
	output logic [15:0] kept_x_from,
	output logic [15:0] kept_y_from,
	output logic [15:0] kept_x_to,
	output logic [15:0] kept_y_to,
	output logic        last_kept,
	output logic        none_kept
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int LSW = 17 + CW;
	localparam int ASW = 16 + CW;
	localparam int LQW = 34 + CW;
	localparam int AQW = 32 + CW;

	mvof_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [16:0] max_dist_q;
	logic [3:0]  dist_k_q, ang_k_q;

	// Captured input item.
	logic [15:0] xf_q, yf_q, xt_q, yt_q;
	logic        trk_q, last_q;

	// Root and CORDIC unit.
	logic [33:0] rv_q, rr_q, rb_q;
	logic signed [19:0] cx_q, cy_q;
	logic signed [21:0] cz_q;
	logic        neg_q, zero_q;
	logic [4:0]  it_q;

	// Per pair results.
	logic [16:0] len_q;
	logic [15:0] ang_q, prev_ang_q;
	logic [33:0] lsq_q;
	logic [31:0] asq_q;

	// Set state.
	logic [CW-1:0]  count_q;
	logic [LSW-1:0] lsum_q;
	logic [ASW-1:0] asum_q;
	logic [LQW-1:0] lqsum_q;
	logic [AQW-1:0] aqsum_q;

	// Band setup.
	logic [2*LSW-1:0] lnq_q, lss_q, lvar_q;
	logic [2*ASW-1:0] anq_q, ass_q, avar_q;
	logic [7:0]       dkk_q, akk_q;
	logic [2*LSW+7:0] lbound_q;
	logic [2*ASW+7:0] abound_q;

	// Filter walk.
	logic [CW-1:0]       idx_q;
	logic [mvof_pkg::ENTRY_W-1:0] rdata;
	logic [63:0]         pr_s1;
	logic                trk_s1;
	logic [16:0]         len_s1;
	logic [LSW-1:0]      lnv_s1;
	logic [ASW-1:0]      anv_s1;
	logic [LSW-1:0]      la_s2;
	logic [ASW-1:0]      aa_s2;
	logic                lgt_s2, agt_s2;
	logic [2*LSW-1:0]    la2_s3;
	logic [2*ASW-1:0]    aa2_s3;
	logic                lgt_s3, agt_s3;
	logic [63:0]         pend_q;
	logic                pend_v_q;
	logic                keep;

	// Output registers.
	logic        strobe_q, last_kept_q, none_kept_q;
	logic [63:0] out_q;

	// CORDIC iteration and angle finishing.
	logic signed [19:0] cxs, cys;
	logic signed [21:0] step_s, zc;
	logic [15:0]        ang_raw, ang_fold;
	logic [33:0]        rsum;

	assign cxs    = cx_q >>> it_q[3:0];
	assign cys    = cy_q >>> it_q[3:0];
	assign step_s = 22'(mvof_pkg::atan_step(it_q[3:0]));
	assign rsum   = rr_q + rb_q;

	always_comb begin
		if (cz_q < 0) begin
			zc = '0;
		end else if (cz_q > 22'sd524288) begin
			zc = 22'sd524288;
		end else begin
			zc = cz_q;
		end
		ang_raw  = zc[19:4];
		ang_fold = neg_q ? 16'(17'h10000 - 17'(ang_raw)) : ang_raw;
	end

	// Drop decision for the pair in the last stage.
	assign keep = trk_s1
		&& !(lgt_s3 && ((2*LSW+8)'(la2_s3) > lbound_q))
		&& !(agt_s3 && ((2*ASW+8)'(aa2_s3) > abound_q))
		&& !(len_s1 > max_dist_q);

	mvof_ram #(
		.WIDTH (mvof_pkg::ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (state_q == mvof_pkg::ST_SQ),
		.waddr (count_q[AW-1:0]),
		.wdata ({trk_q, len_q, ang_q, yt_q, xt_q, yf_q, xf_q}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvof_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mvof_pkg::ST_IDLE: begin
				if (start) begin
					if (count_q < CW'(MAX_POINTS)) begin
						state_d = mvof_pkg::ST_SQR;
					end else if (last_point) begin
						state_d = mvof_pkg::ST_PREP1;
					end
				end
			end
			mvof_pkg::ST_SQR:  state_d = mvof_pkg::ST_ITER;
			mvof_pkg::ST_ITER: begin
				if (it_q == 5'd16) begin
					state_d = mvof_pkg::ST_FIN;
				end
			end
			mvof_pkg::ST_FIN:  state_d = mvof_pkg::ST_SQ;
			mvof_pkg::ST_SQ:   state_d = mvof_pkg::ST_ACC;
			mvof_pkg::ST_ACC:  state_d = last_q ? mvof_pkg::ST_PREP1 : mvof_pkg::ST_IDLE;
			mvof_pkg::ST_PREP1: state_d = mvof_pkg::ST_PREP2;
			mvof_pkg::ST_PREP2: state_d = mvof_pkg::ST_PREP3;
			mvof_pkg::ST_PREP3: begin
				state_d = (count_q == '0) ? mvof_pkg::ST_DONE : mvof_pkg::ST_RD;
			end
			mvof_pkg::ST_RD:  state_d = mvof_pkg::ST_EV1;
			mvof_pkg::ST_EV1: state_d = mvof_pkg::ST_EV2;
			mvof_pkg::ST_EV2: state_d = mvof_pkg::ST_EV3;
			mvof_pkg::ST_EV3: state_d = mvof_pkg::ST_EV4;
			mvof_pkg::ST_EV4: begin
				state_d = (idx_q + 1'b1 < count_q) ? mvof_pkg::ST_RD : mvof_pkg::ST_DONE;
			end
			mvof_pkg::ST_DONE: state_d = mvof_pkg::ST_IDLE;
			default: state_d = mvof_pkg::ST_IDLE;
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= 17'd480;
			dist_k_q   <= 4'd2;
			ang_k_q    <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mvof_pkg::CFG_MAX_DISTANCE: max_dist_q <= cfg_data;
				mvof_pkg::CFG_DIST_SIGMA:   dist_k_q   <= cfg_data[3:0];
				mvof_pkg::CFG_ANGLE_SIGMA:  ang_k_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Set counters, sums, walk index, output flags and pending flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			lsum_q      <= '0;
			asum_q      <= '0;
			lqsum_q     <= '0;
			aqsum_q     <= '0;
			idx_q       <= '0;
			pend_v_q    <= 1'b0;
			strobe_q    <= 1'b0;
			last_kept_q <= 1'b0;
			none_kept_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				mvof_pkg::ST_ACC: begin
					count_q <= count_q + 1'b1;
					lsum_q  <= lsum_q + LSW'(len_q);
					asum_q  <= asum_q + ASW'(ang_q);
					lqsum_q <= lqsum_q + LQW'(lsq_q);
					aqsum_q <= aqsum_q + AQW'(asq_q);
				end
				mvof_pkg::ST_PREP1: begin
					idx_q    <= '0;
					pend_v_q <= 1'b0;
				end
				mvof_pkg::ST_EV4: begin
					idx_q <= idx_q + 1'b1;
					if (keep) begin
						pend_v_q <= 1'b1;
						if (pend_v_q) begin
							strobe_q    <= 1'b1;
							last_kept_q <= 1'b0;
							none_kept_q <= 1'b0;
						end
					end
				end
				mvof_pkg::ST_DONE: begin
					strobe_q    <= 1'b1;
					last_kept_q <= 1'b1;
					none_kept_q <= !pend_v_q;
					pend_v_q    <= 1'b0;
					count_q     <= '0;
					lsum_q      <= '0;
					asum_q      <= '0;
					lqsum_q     <= '0;
					aqsum_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			mvof_pkg::ST_IDLE: begin
				xf_q   <= x_from;
				yf_q   <= y_from;
				xt_q   <= x_to;
				yt_q   <= y_to;
				trk_q  <= tracked;
				last_q <= last_point;
			end
			mvof_pkg::ST_SQR: begin
				logic signed [16:0] dx, dy;
				logic [15:0] ax, ay;
				dx = 17'(xt_q) - 17'(xf_q);
				dy = 17'(yt_q) - 17'(yf_q);
				ax = dx[16] ? 16'(-dx) : dx[15:0];
				ay = dy[16] ? 16'(-dy) : dy[15:0];
				rv_q   <= 34'(32'(ax) * 32'(ax)) + 34'(32'(ay) * 32'(ay));
				zero_q <= (dx == '0) && (dy == '0);
				rr_q   <= '0;
				rb_q   <= 34'(1) << 32;
				it_q   <= '0;
				neg_q  <= dy[16];
				if (dy[16]) begin
					cx_q <= 20'(ax);
					cy_q <= 20'(ay);
					cz_q <= 22'sd262144;
				end else begin
					cx_q <= 20'(dy);
					cy_q <= 20'(ax);
					cz_q <= '0;
				end
			end
			mvof_pkg::ST_ITER: begin
				// One root step per cycle, plus one CORDIC step while it_q is below 16.
				if (rv_q >= rsum) begin
					rv_q <= rv_q - rsum;
					rr_q <= (rr_q >> 1) + rb_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				rb_q <= rb_q >> 2;
				it_q <= it_q + 1'b1;
				if (!it_q[4]) begin
					if (cy_q >= 0) begin
						cx_q <= cx_q + cys;
						cy_q <= cy_q - cxs;
						cz_q <= cz_q + step_s;
					end else begin
						cx_q <= cx_q - cys;
						cy_q <= cy_q + cxs;
						cz_q <= cz_q - step_s;
					end
				end
			end
			mvof_pkg::ST_FIN: begin
				len_q <= rr_q[16:0];
				if (zero_q) begin
					ang_q <= (count_q == '0) ? 16'd0 : prev_ang_q;
				end else begin
					ang_q <= ang_fold;
				end
			end
			mvof_pkg::ST_SQ: begin
				lsq_q      <= 34'(len_q) * 34'(len_q);
				asq_q      <= 32'(ang_q) * 32'(ang_q);
				prev_ang_q <= ang_q;
			end
			mvof_pkg::ST_PREP1: begin
				lnq_q <= (2*LSW)'(count_q) * (2*LSW)'(lqsum_q);
				lss_q <= (2*LSW)'(lsum_q) * (2*LSW)'(lsum_q);
				anq_q <= (2*ASW)'(count_q) * (2*ASW)'(aqsum_q);
				ass_q <= (2*ASW)'(asum_q) * (2*ASW)'(asum_q);
				dkk_q <= 8'(dist_k_q) * 8'(dist_k_q);
				akk_q <= 8'(ang_k_q) * 8'(ang_k_q);
			end
			mvof_pkg::ST_PREP2: begin
				lvar_q <= lnq_q - lss_q;
				avar_q <= anq_q - ass_q;
			end
			mvof_pkg::ST_PREP3: begin
				lbound_q <= (2*LSW+8)'(dkk_q) * (2*LSW+8)'(lvar_q);
				abound_q <= (2*ASW+8)'(akk_q) * (2*ASW+8)'(avar_q);
			end
			mvof_pkg::ST_EV1: begin
				pr_s1  <= rdata[63:0];
				trk_s1 <= rdata[97];
				len_s1 <= rdata[96:80];
				lnv_s1 <= LSW'(count_q) * LSW'(rdata[96:80]);
				anv_s1 <= ASW'(count_q) * ASW'(rdata[79:64]);
			end
			mvof_pkg::ST_EV2: begin
				lgt_s2 <= lnv_s1 > lsum_q;
				agt_s2 <= anv_s1 > asum_q;
				la_s2  <= lnv_s1 - lsum_q;
				aa_s2  <= anv_s1 - asum_q;
			end
			mvof_pkg::ST_EV3: begin
				lgt_s3 <= lgt_s2;
				agt_s3 <= agt_s2;
				la2_s3 <= (2*LSW)'(la_s2) * (2*LSW)'(la_s2);
				aa2_s3 <= (2*ASW)'(aa_s2) * (2*ASW)'(aa_s2);
			end
			mvof_pkg::ST_EV4: begin
				if (keep) begin
					pend_q <= pr_s1;
					out_q  <= pend_q;
				end
			end
			mvof_pkg::ST_DONE: begin
				out_q <= pend_v_q ? pend_q : 64'd0;
			end
			default: ;
		endcase
	end

	assign busy        = state_q != mvof_pkg::ST_IDLE;
	assign strobe      = strobe_q;
	assign kept_x_from = out_q[15:0];
	assign kept_y_from = out_q[31:16];
	assign kept_x_to   = out_q[47:32];
	assign kept_y_to   = out_q[63:48];
	assign last_kept   = last_kept_q;
	assign none_kept   = none_kept_q;

`ifndef SYNTHESIS
	// An empty run is always the final result.
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && none_kept |-> last_kept) else $error("none_kept without last_kept");

	// The set never holds more pairs than the memory.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS)) else $error("pair count overflow");

	// A result that is not the last one leaves the block still busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_kept |-> busy) else $error("idle before final result");

	// Every accumulate step adds exactly one pair.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mvof_pkg::ST_ACC |=> count_q == $past(count_q) + 1'b1)
		else $error("pair count step");
`endif

endmodule

// ===== sim/tb_motion_vector_outlier_filter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Motion vector outlier filter core testbench
// Loads sets of point pairs through the start/busy port and rebuilds the
// length, angle and band statistics of each set in a behavioral predictor.
// Every strobed result is compared with the oldest predicted kept pair.
// The run covers directed corner cases, set overflow, register extremes and
// random sets under several sender idle patterns.
// ---------------------------------------------------------------------------
module tb_motion_vector_outlier_filter_core;

	localparam int SET_CAP     = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		logic [15:0] xf, yf, xt, yt;
		logic        trk;
		logic [16:0] len;
		logic [15:0] ang;
	} held_pair_t;

	typedef struct {
		logic [15:0] xf, yf, xt, yt;
		logic        fin, none;
	} kept_pair_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] x_from, y_from, x_to, y_to;
	logic        tracked, last_point;
	logic        cfg_write;
	logic [mvof_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mvof_pkg::CFG_W-1:0]     cfg_data;
	logic        strobe;
	logic [15:0] kept_x_from, kept_y_from, kept_x_to, kept_y_to;
	logic        last_kept, none_kept;

	motion_vector_outlier_filter_core #(.MAX_POINTS(SET_CAP)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_from(x_from), .y_from(y_from), .x_to(x_to), .y_to(y_to),
		.tracked(tracked), .last_point(last_point),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .kept_x_from(kept_x_from), .kept_y_from(kept_y_from),
		.kept_x_to(kept_x_to), .kept_y_to(kept_y_to),
		.last_kept(last_kept), .none_kept(none_kept)
	);

	// Predictor state: the held set, its sums and the register copies.
	held_pair_t   held_set[SET_CAP];
	int           held_count;
	longint unsigned len_total, ang_total, len_sq_total, ang_sq_total;
	logic [16:0]  max_move;
	logic [3:0]   len_mult, ang_mult;
	kept_pair_t   kept_queue[$];

	int  fail_count;
	int  cycle_count;
	int  idle_pct;

	// Arctangent increments in units of 2pi/2^20.
	localparam longint ATAN_INC[16] = '{131072, 77376, 40884, 20753, 10417, 5213,
		2607, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Integer square root, rounded down.
	function automatic longint unsigned move_length(input longint unsigned v);
		longint unsigned r, bit_w;
		r = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= r + bit_w) begin
				v = v - (r + bit_w);
				r = (r >> 1) + bit_w;
			end else begin
				r = r >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return r;
	endfunction

	// Folded move angle by vectoring CORDIC, in units of 2pi/65536.
	function automatic logic [15:0] move_angle(input longint dx, input longint dy);
		longint x, y, z, t, xs, ys;
		longint unsigned a;
		x = dy;
		y = (dx < 0) ? -dx : dx;
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = 64'sd262144;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_INC[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_INC[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > 64'sd524288)
			z = 64'sd524288;
		a = z >> 4;
		if (dy < 0)
			a = (65536 - a) & 16'hFFFF;
		return a[15:0];
	endfunction

	// True when v lies more than k deviations above the set mean.
	function automatic bit beyond_band(input longint unsigned v, input longint unsigned s,
			input longint unsigned q, input longint unsigned n, input longint unsigned k);
		longint unsigned nv, a, var_n;
		nv = n * v;
		if (nv <= s)
			return 1'b0;
		a = nv - s;
		var_n = n * q - s * s;
		return a * a > k * k * var_n;
	endfunction

	// Adds an accepted pair to the held set; the last pair yields the kept list.
	task automatic absorb_pair(input logic [15:0] xf, yf, xt, yt, input logic trk, fin);
		longint dx, dy;
		held_pair_t p;
		kept_pair_t r;
		int found;
		if (held_count < SET_CAP) begin
			dx = longint'(xt) - longint'(xf);
			dy = longint'(yt) - longint'(yf);
			p.xf = xf; p.yf = yf; p.xt = xt; p.yt = yt; p.trk = trk;
			p.len = 17'(move_length(dx * dx + dy * dy));
			if (dx == 0 && dy == 0)
				p.ang = (held_count == 0) ? 16'd0 : held_set[held_count-1].ang;
			else
				p.ang = move_angle(dx, dy);
			held_set[held_count] = p;
			len_total += p.len;
			ang_total += p.ang;
			len_sq_total += longint'(p.len) * p.len;
			ang_sq_total += longint'(p.ang) * p.ang;
			held_count++;
		end
		if (!fin)
			return;
		found = 0;
		for (int i = 0; i < held_count; i++) begin
			p = held_set[i];
			if (p.trk && !beyond_band(64'(p.len), len_total, len_sq_total,
					64'(held_count), 64'(len_mult))
					&& !beyond_band(64'(p.ang), ang_total, ang_sq_total,
					64'(held_count), 64'(ang_mult))
					&& p.len <= max_move) begin
				r.xf = p.xf; r.yf = p.yf; r.xt = p.xt; r.yt = p.yt;
				r.fin = 1'b0; r.none = 1'b0;
				kept_queue.push_back(r);
				found++;
			end
		end
		if (found == 0) begin
			r.xf = '0; r.yf = '0; r.xt = '0; r.yt = '0;
			r.fin = 1'b1; r.none = 1'b1;
			kept_queue.push_back(r);
		end else begin
			kept_queue[$].fin = 1'b1;
		end
		held_count = 0;
		len_total = 0; ang_total = 0; len_sq_total = 0; ang_sq_total = 0;
	endtask

	// Result checker: each strobed transfer against the oldest prediction.
	always @(posedge clk) begin
		kept_pair_t e;
		if (arst_n && strobe) begin
			if (kept_queue.size() == 0) begin
				$error("unexpected result transfer");
				fail_count++;
			end else begin
				e = kept_queue.pop_front();
				if (kept_x_from !== e.xf) begin
					$error("kept_x_from exp %0d got %0d", e.xf, kept_x_from); fail_count++;
				end
				if (kept_y_from !== e.yf) begin
					$error("kept_y_from exp %0d got %0d", e.yf, kept_y_from); fail_count++;
				end
				if (kept_x_to !== e.xt) begin
					$error("kept_x_to exp %0d got %0d", e.xt, kept_x_to); fail_count++;
				end
				if (kept_y_to !== e.yt) begin
					$error("kept_y_to exp %0d got %0d", e.yt, kept_y_to); fail_count++;
				end
				if (last_kept !== e.fin) begin
					$error("last_kept exp %0d got %0d", e.fin, last_kept); fail_count++;
				end
				if (none_kept !== e.none) begin
					$error("none_kept exp %0d got %0d", e.none, none_kept); fail_count++;
				end
			end
		end
	end

	// Sends one pair; returns at the edge where the transfer happened.
	// In each cycle the sender idles with a chance of idle_pct percent.
	task automatic send_pair(input logic [15:0] xf, yf, xt, yt, input logic trk, fin);
		x_from <= xf; y_from <= yf; x_to <= xt; y_to <= yt;
		tracked <= trk; last_point <= fin;
		forever begin
			if (int'($urandom_range(99)) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end else begin
				start <= 1'b1;
				@(posedge clk);
				if (!busy)
					break;
			end
		end
		absorb_pair(xf, yf, xt, yt, trk, fin);
	endtask

	// Holds the sender until every predicted result has come, then settles.
	task automatic drain_results();
		start <= 1'b0;
		while (kept_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mvof_pkg::CFG_IDX_W-1:0] idx,
			input logic [mvof_pkg::CFG_W-1:0] val);
		drain_results();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			mvof_pkg::CFG_MAX_DISTANCE: max_move = val;
			mvof_pkg::CFG_DIST_SIGMA:   len_mult = val[3:0];
			mvof_pkg::CFG_ANGLE_SIGMA:  ang_mult = val[3:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [16:0] md, input logic [3:0] dk, input logic [3:0] ak);
		write_reg(mvof_pkg::CFG_MAX_DISTANCE, md);
		write_reg(mvof_pkg::CFG_DIST_SIGMA, {13'd0, dk});
		write_reg(mvof_pkg::CFG_ANGLE_SIGMA, {13'd0, ak});
	endtask

	// A well-formed set of n pairs, mostly short tracked moves.
	task automatic send_random_set(input int n);
		logic [15:0] xf, yf, xt, yt;
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = int'($urandom_range(9));
			xf = 16'($urandom); yf = 16'($urandom);
			if (mode == 0) begin
				xt = 16'($urandom); yt = 16'($urandom);
			end else if (mode == 1) begin
				xt = xf; yt = yf;
			end else begin
				xt = xf + 16'($urandom_range(0, 640)) - 16'd320;
				yt = yf + 16'($urandom_range(0, 640)) - 16'd320;
			end
			send_pair(xf, yf, xt, yt, $urandom_range(9) != 0, i == n - 1);
		end
	endtask

	// Field extremes as two unkept lone pairs, then axis and diagonal directions.
	task automatic test_extremes();
		send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1);
		send_pair(16'h1000, 16'h1000, 16'h1010, 16'h1000, 1'b1, 1'b0);
		send_pair(16'h1000, 16'h1000, 16'h0FF0, 16'h1000, 1'b1, 1'b0);
		send_pair(16'h1000, 16'h1000, 16'h1000, 16'h1010, 1'b1, 1'b0);
		send_pair(16'h1000, 16'h1000, 16'h1000, 16'h0FF0, 1'b1, 1'b0);
		send_pair(16'h1000, 16'h1000, 16'h0FF0, 16'h0FF0, 1'b1, 1'b0);
		send_pair(16'h1000, 16'h1000, 16'h1010, 16'h0FF0, 1'b1, 1'b1);
	endtask

	// Zero-length moves, first and later, and untracked pairs.
	task automatic test_special_cases();
		send_pair(16'h2000, 16'h3000, 16'h2000, 16'h3000, 1'b1, 1'b0);
		send_pair(16'h2000, 16'h3000, 16'h2020, 16'h2FE0, 1'b1, 1'b0);
		send_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0);
		send_pair(16'h2000, 16'h3000, 16'h2008, 16'h3004, 1'b0, 1'b1);
		send_pair(16'h4000, 16'h4000, 16'h4010, 16'h4010, 1'b0, 1'b1);
		send_pair(16'h7000, 16'h7000, 16'h7000, 16'h7000, 1'b1, 1'b1);
	endtask

	// A set larger than the store: extra pairs are ignored but the last one ends it.
	task automatic test_overflow();
		drain_results();
		send_random_set(SET_CAP + 3);
	endtask

	// Register extremes and one middle distance setting.
	task automatic test_register_sweep();
		write_all(17'd0, 4'd0, 4'd0);
		send_random_set(5);
		write_all(17'h1FFFF, 4'd15, 4'd15);
		send_random_set(6);
		write_all(17'h1FFFF, 4'd0, 4'd15);
		send_random_set(6);
		write_all(17'd160, 4'd15, 4'd0);
		send_random_set(6);
	endtask

	// Random sets, mostly small, with register changes between them.
	task automatic test_random_sets(input int pct, input int pairs);
		int sent, n;
		idle_pct = pct;
		sent = 0;
		while (sent < pairs) begin
			if ($urandom_range(3) == 0)
				write_all(17'($urandom_range(0, 131071) >> $urandom_range(0, 8)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			n = ($urandom_range(9) == 0) ? int'($urandom_range(13, 40))
				: int'($urandom_range(1, 12));
			send_random_set(n);
			sent += n;
		end
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		idle_pct = 11;
		held_count = 0;
		len_total = 0; ang_total = 0; len_sq_total = 0; ang_sq_total = 0;
		max_move = 17'd480;
		len_mult = 4'd2;
		ang_mult = 4'd1;
		arst_n = 1'b0;
		start = 1'b0;
		x_from = '0; y_from = '0; x_to = '0; y_to = '0;
		tracked = 1'b0; last_point = 1'b0;
		cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_special_cases();
		test_overflow();
		test_register_sweep();
		test_random_sets(11, 120);
		test_random_sets(50, 120);
		test_random_sets(0, 120);

		start <= 1'b0;
		while (kept_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mvof_pkg.sv
rtl/core/mvof_ram.sv
rtl/core/motion_vector_outlier_filter_core.sv
sim/tb_motion_vector_outlier_filter_core.sv
